### rtl/tpq_pkg.sv
`timescale 1ns / 1ps

package tpq_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_ARM    = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic CFG_RELEASE_TIME = 1'b0;
  localparam logic CFG_PRESS_TIME   = 1'b1;

  localparam logic [CfgW-1:0] RELEASE_TIME_RESET = 16'd200;
  localparam logic [CfgW-1:0] PRESS_TIME_RESET   = 16'd50;

  typedef struct packed {
    logic [1:0]       action;
    logic             touch_level;
    logic [TimeW-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic press_valid;
    logic lockout_active;
  } out_item_t;

endpackage

### rtl/tpq_engine.sv
`timescale 1ns / 1ps

module tpq_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_wdata,
  input  logic                  take,
  input  tpq_pkg::in_item_t     item,
  output tpq_pkg::out_item_t    result
);

  logic [tpq_pkg::CfgW-1:0]  release_time_r;
  logic [tpq_pkg::CfgW-1:0]  press_time_r;
  logic                      last_level_r, last_level_nxt;
  logic                      lockout_r, lockout_nxt;
  logic [tpq_pkg::TimeW-1:0] release_start_r, release_start_nxt;
  logic                      release_timing_r, release_timing_nxt;
  logic [tpq_pkg::TimeW-1:0] press_start_r, press_start_nxt;
  logic                      press_timing_r, press_timing_nxt;

  logic                      touched;
  logic                      timing_held;
  logic                      release_done;
  logic                      lockout_now;
  logic [tpq_pkg::TimeW-1:0] rel_elapsed;
  logic [tpq_pkg::TimeW-1:0] press_elapsed;
  logic                      press_ok;

  assign touched       = item.touch_level;
  assign timing_held   = press_timing_r & ~(touched & ~last_level_r);
  assign rel_elapsed   = item.time_ms - release_start_r;
  assign press_elapsed = item.time_ms - press_start_r;
  assign release_done  = lockout_r & ~touched & release_timing_r &
                         (rel_elapsed > {{(tpq_pkg::TimeW-tpq_pkg::CfgW){1'b0}},
                                         release_time_r});
  assign lockout_now   = lockout_r & ~release_done;
  assign press_ok      = timing_held &
                         (press_elapsed > {{(tpq_pkg::TimeW-tpq_pkg::CfgW){1'b0}},
                                           press_time_r});

  always_comb begin
    last_level_nxt     = last_level_r;
    lockout_nxt        = lockout_r;
    release_start_nxt  = release_start_r;
    release_timing_nxt = release_timing_r;
    press_start_nxt    = press_start_r;
    press_timing_nxt   = press_timing_r;
    result.press_valid    = 1'b0;
    result.lockout_active = lockout_r;
    case (item.action)
      tpq_pkg::ACT_ARM: begin
        lockout_nxt        = 1'b1;
        release_timing_nxt = 1'b0;
        release_start_nxt  = '0;
      end
      tpq_pkg::ACT_CLEAR: begin
        lockout_nxt        = 1'b0;
        release_timing_nxt = 1'b0;
        release_start_nxt  = '0;
      end
      tpq_pkg::ACT_SAMPLE: begin
        last_level_nxt   = touched;
        press_timing_nxt = timing_held;
        if (lockout_r && !touched) begin
          if (!release_timing_r) begin
            release_start_nxt  = item.time_ms;
            release_timing_nxt = 1'b1;
          end else if (release_done) begin
            lockout_nxt        = 1'b0;
            release_timing_nxt = 1'b0;
            release_start_nxt  = '0;
          end
        end
        if (touched && !lockout_now) begin
          if (!timing_held) begin
            press_start_nxt  = item.time_ms;
            press_timing_nxt = 1'b1;
          end
          result.press_valid = press_ok;
        end
      end
      default: begin
      end
    endcase
    result.lockout_active = lockout_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_time_r   <= tpq_pkg::RELEASE_TIME_RESET;
      press_time_r     <= tpq_pkg::PRESS_TIME_RESET;
      last_level_r     <= 1'b0;
      lockout_r        <= 1'b0;
      release_start_r  <= '0;
      release_timing_r <= 1'b0;
      press_start_r    <= '0;
      press_timing_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == tpq_pkg::CFG_RELEASE_TIME) begin
        release_time_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == tpq_pkg::CFG_PRESS_TIME) begin
        press_time_r <= cfg_wdata;
      end
      if (take) begin
        last_level_r     <= last_level_nxt;
        lockout_r        <= lockout_nxt;
        release_start_r  <= release_start_nxt;
        release_timing_r <= release_timing_nxt;
        press_start_r    <= press_start_nxt;
        press_timing_r   <= press_timing_nxt;
      end
    end
  end

  // An accepted arm command leaves lockout set with the release timer stopped.
  a_arm_sets_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.action == tpq_pkg::ACT_ARM |=> lockout_r && !release_timing_r)
    else $error("arm command did not set lockout");

  // A press is never reported while lockout remains set after the item.
  a_no_press_in_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    take && result.press_valid |-> !result.lockout_active)
    else $error("press reported during lockout");

  // Commands and unused codes never report a press.
  a_press_only_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.action != tpq_pkg::ACT_SAMPLE |-> !result.press_valid)
    else $error("press reported on a command");

  // The release timer only runs while lockout is set.
  a_release_needs_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    release_timing_r |-> lockout_r)
    else $error("release timer running without lockout");

endmodule

### rtl/tpq_out_buf.sv
`timescale 1ns / 1ps

module tpq_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tpq_pkg::out_item_t push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output tpq_pkg::out_item_t out_data
);

  tpq_pkg::out_item_t mem_r [2];
  logic [1:0]         count_r, count_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               pop;

  assign space     = ~count_r[1];
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;

  always_comb begin
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> space)
    else $error("result buffer written while full");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> rd_ptr_r == wr_ptr_r)
    else $error("result buffer pointers disagree with count");

endmodule

### rtl/touch_press_qualifier_core.sv
`timescale 1ns / 1ps

// Each accepted item's result is written into the result buffer and offered from there.
// Throughput: one item per cycle while the buffer has space; its two entries keep the input
// open while a finished result waits for its output transfer.
// Reset: synchronous, active low; it clears all timers and flags, empties the
// result buffer and loads release_time_ms = 200 and press_time_ms = 50.
module touch_press_qualifier_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tpq_pkg::out_item_t out_data
);

  logic               take;
  tpq_pkg::out_item_t result;

  assign take = in_valid & in_ready;

  tpq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .item      (in_data),
    .result    (result)
  );

  tpq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;

  class press_scoreboard;
    logic [15:0] release_limit;
    logic [15:0] press_limit;
    logic        last_level;
    logic        lockout;
    logic        release_timing;
    logic        press_timing;
    logic [31:0] release_start;
    logic [31:0] press_start;
    tpq_pkg::out_item_t expected_reports[$];
    int          mismatches;

    function new();
      release_limit = tpq_pkg::RELEASE_TIME_RESET;
      press_limit = tpq_pkg::PRESS_TIME_RESET;
      last_level = 1'b0;
      lockout = 1'b0;
      release_timing = 1'b0;
      press_timing = 1'b0;
      release_start = '0;
      press_start = '0;
      mismatches = 0;
    endfunction

    function void set_limits(logic [15:0] rel, logic [15:0] prs);
      release_limit = rel;
      press_limit = prs;
    endfunction

    function tpq_pkg::out_item_t qualify(tpq_pkg::in_item_t it);
      tpq_pkg::out_item_t r;
      logic [31:0]        elapsed;
      r.press_valid = 1'b0;
      case (it.action)
        tpq_pkg::ACT_ARM: begin
          lockout = 1'b1;
          release_timing = 1'b0;
          release_start = '0;
        end
        tpq_pkg::ACT_CLEAR: begin
          lockout = 1'b0;
          release_timing = 1'b0;
          release_start = '0;
        end
        tpq_pkg::ACT_SAMPLE: begin
          if (it.touch_level && !last_level) begin
            press_timing = 1'b0;
          end
          last_level = it.touch_level;
          if (lockout && !it.touch_level) begin
            if (!release_timing) begin
              release_start = it.time_ms;
              release_timing = 1'b1;
            end else begin
              elapsed = it.time_ms - release_start;
              if (elapsed > {16'b0, release_limit}) begin
                lockout = 1'b0;
                release_timing = 1'b0;
                release_start = '0;
              end
            end
          end
          if (it.touch_level && !lockout) begin
            if (!press_timing) begin
              press_start = it.time_ms;
              press_timing = 1'b1;
            end
            elapsed = it.time_ms - press_start;
            r.press_valid = elapsed > {16'b0, press_limit};
          end
        end
        default: ;
      endcase
      r.lockout_active = lockout;
      return r;
    endfunction

    function void note_transfer(tpq_pkg::in_item_t it);
      expected_reports.push_back(qualify(it));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_report(tpq_pkg::out_item_t got);
      tpq_pkg::out_item_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch("result transfer with no result expected");
      end else begin
        want = expected_reports.pop_front();
        if (got.press_valid !== want.press_valid) begin
          report_mismatch($sformatf("press_valid got %b expected %b",
                                    got.press_valid, want.press_valid));
        end
        if (got.lockout_active !== want.lockout_active) begin
          report_mismatch($sformatf("lockout_active got %b expected %b",
                                    got.lockout_active, want.lockout_active));
        end
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  tpq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  tpq_pkg::out_item_t out_data;

  press_scoreboard sb;
  logic [31:0]     clock_ms;
  logic            calm;
  int unsigned     cycle_count;

  touch_press_qualifier_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(input tpq_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_transfer(it);
  endtask

  task automatic send_sample(input logic level, input int unsigned delta);
    tpq_pkg::in_item_t it;
    clock_ms = clock_ms + delta;
    it.action = tpq_pkg::ACT_SAMPLE;
    it.touch_level = level;
    it.time_ms = clock_ms;
    push_item(it);
  endtask

  task automatic send_sample_at(input logic level, input logic [31:0] stamp);
    clock_ms = stamp;
    send_sample(level, 0);
  endtask

  task automatic send_command(input logic [1:0] act);
    tpq_pkg::in_item_t it;
    it.action = act;
    it.touch_level = 1'($urandom_range(0, 1));
    it.time_ms = $urandom;
    push_item(it);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] rel, input logic [15:0] prs);
    cfg_we <= 1'b1;
    cfg_index <= tpq_pkg::CFG_RELEASE_TIME;
    cfg_wdata <= rel;
    @(posedge clk);
    cfg_index <= tpq_pkg::CFG_PRESS_TIME;
    cfg_wdata <= prs;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limits(rel, prs);
  endtask

  task automatic random_phase(input int n, input int unsigned dmax);
    int done_items;
    int r;
    int len_on;
    int len_off;
    logic noise;
    done_items = 0;
    while (done_items < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_command(tpq_pkg::ACT_ARM);
        done_items++;
      end else if (r < 11) begin
        send_command(tpq_pkg::ACT_CLEAR);
        done_items++;
      end else if (r < 13) begin
        send_command(ACT_RESERVED);
      end else if (r < 16) begin
        send_sample_at(1'($urandom_range(0, 1)), $urandom);
        done_items++;
      end else begin
        len_on = $urandom_range(1, 8);
        len_off = $urandom_range(1, 8);
        for (int k = 0; k < len_on; k++) begin
          noise = ($urandom_range(0, 99) < 8);
          send_sample(1'b1 ^ noise, $urandom_range(0, dmax));
        end
        for (int k = 0; k < len_off; k++) begin
          noise = ($urandom_range(0, 99) < 8);
          send_sample(1'b0 ^ noise, $urandom_range(0, dmax));
        end
        done_items += len_on + len_off;
      end
    end
  endtask

  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (pick_gap() + 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      sb.check_report(out_data);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [15:0] rel;
    logic [15:0] prs;
    int unsigned dmax;
    sb = new();
    calm = 1'b0;
    clock_ms = 32'hFFFF_FFF0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= tpq_pkg::CFG_RELEASE_TIME;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds; the press timer crosses the timestamp wrap.
    send_sample(1'b0, 0);
    send_sample(1'b1, 5);
    send_sample(1'b1, 50);
    send_sample(1'b1, 1);
    send_command(tpq_pkg::ACT_ARM);
    send_sample(1'b1, 10);
    send_sample(1'b0, 10);
    send_sample(1'b0, 200);
    send_sample(1'b0, 1);
    send_sample(1'b1, 3);
    send_command(ACT_RESERVED);
    send_sample(1'b1, 60);
    send_command(tpq_pkg::ACT_ARM);
    send_command(tpq_pkg::ACT_CLEAR);
    send_sample(1'b1, 1);
    send_sample_at(1'b1, 32'hFFFF_FFFF);
    send_sample_at(1'b0, 32'h0000_0000);
    finish_phase();

    configure(16'd0, 16'd0);
    send_sample(1'b1, 0);
    send_sample(1'b1, 0);
    send_sample(1'b1, 1);
    send_command(tpq_pkg::ACT_ARM);
    send_sample(1'b0, 0);
    send_sample(1'b0, 0);
    send_sample(1'b0, 1);
    finish_phase();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          rel = 16'hFFFF;
          prs = 16'hFFFF;
        end
        1: begin
          rel = 16'd0;
          prs = 16'd0;
        end
        2: begin
          rel = 16'($urandom_range(1, 40));
          prs = 16'($urandom_range(1, 40));
        end
        3: begin
          rel = 16'($urandom_range(0, 65535));
          prs = 16'($urandom_range(0, 65535));
        end
        4: begin
          rel = tpq_pkg::RELEASE_TIME_RESET;
          prs = tpq_pkg::PRESS_TIME_RESET;
        end
        default: begin
          rel = 16'($urandom_range(0, 20));
          prs = 16'($urandom_range(100, 300));
        end
      endcase
      configure(rel, prs);
      calm = (p == 2);
      dmax = ((rel > prs) ? rel : prs) / 3 + 2;
      random_phase(85, dmax);
      finish_phase();
    end

    calm = 1'b0;
    repeat (10) @(posedge clk);
    if (sb.expected_reports.size() != 0) begin
      sb.report_mismatch("expected results left over at end of run");
    end
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tpq_pkg.sv
rtl/tpq_engine.sv
rtl/tpq_out_buf.sv
rtl/touch_press_qualifier_core.sv
dv/testbench.sv
